[design/uvs_pkg.sv]
package uvs_pkg;

  localparam int unsigned MillisW = 48;
  localparam int unsigned SeedW   = 41;
  localparam int unsigned RandW   = 32;
  localparam int unsigned CountW  = 42;
  localparam int unsigned HalfW   = 64;

  localparam logic [3:0] UuidVersion = 4'd7;
  localparam logic [1:0] UuidVariant = 2'd2;

  typedef struct packed {
    logic               row_is_null;
    logic [MillisW-1:0] millis;
    logic [SeedW-1:0]   random_seed;
    logic [RandW-1:0]   random_low;
  } row_t;

  typedef struct packed {
    logic [HalfW-1:0] uuid_high;
    logic [HalfW-1:0] uuid_low;
    logic             is_null;
  } result_t;

endpackage

[design/uvs_if.sv]
interface uvs_row_if;
  logic                              valid;
  logic                              ready;
  logic                              row_is_null;
  logic [uvs_pkg::MillisW-1:0]       millis;
  logic [uvs_pkg::SeedW-1:0]         random_seed;
  logic [uvs_pkg::RandW-1:0]         random_low;

  modport source (output valid, row_is_null, millis, random_seed, random_low, input ready);
  modport sink   (input valid, row_is_null, millis, random_seed, random_low, output ready);
endinterface

interface uvs_uuid_if;
  logic                        valid;
  logic                        ready;
  logic [uvs_pkg::HalfW-1:0]   uuid_high;
  logic [uvs_pkg::HalfW-1:0]   uuid_low;
  logic                        is_null;

  modport source (output valid, uuid_high, uuid_low, is_null, input ready);
  modport sink   (input valid, uuid_high, uuid_low, is_null, output ready);
endinterface

[design/uuid_v7_counter_stamper.sv]
// A row is held in the input register stage, and its result is registered in the result
// register stage, from which uuid_o offers it.
// Throughput: one transaction per cycle while uuid_o is ready, set by the counter update loop.
// Reset: asynchronous, active low; it empties both pipeline registers and clears the
// stored timestamps and the counter, so the first non-null row after reset always seeds the counter.
module uuid_v7_counter_stamper (
  input  logic              clk_i,
  input  logic              rst_ni,
  uvs_row_if.sink           row_i,
  uvs_uuid_if.source        uuid_o
);

  // Input register stage. A row waits here until the result register can take
  // its outcome; the counter state is updated at that same edge, so the next
  // row in this stage always sees the state its predecessor left behind.
  logic             in_v_q, in_v_d;
  uvs_pkg::row_t    in_q;

  // Result register stage.
  logic             out_v_q, out_v_d;
  uvs_pkg::result_t out_q;

  uvs_pkg::result_t res;
  logic             advance;

  // The row moves on whenever the result register is empty or being drained.
  assign advance     = in_v_q && (!out_v_q || uuid_o.ready);
  assign row_i.ready = !in_v_q || advance;

  always_comb begin
    in_v_d = in_v_q;
    if (row_i.ready) begin
      in_v_d = row_i.valid;
    end
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (uuid_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  uvs_seq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .row_i  (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (row_i.ready && row_i.valid) begin
      in_q.row_is_null <= row_i.row_is_null;
      in_q.millis      <= row_i.millis;
      in_q.random_seed <= row_i.random_seed;
      in_q.random_low  <= row_i.random_low;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign uuid_o.valid     = out_v_q;
  assign uuid_o.uuid_high = out_q.uuid_high;
  assign uuid_o.uuid_low  = out_q.uuid_low;
  assign uuid_o.is_null   = out_q.is_null;

endmodule

[design/uvs_seq_core.sv]
module uvs_seq_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  uvs_pkg::row_t    row_i,
  output uvs_pkg::result_t res_o
);

  logic [uvs_pkg::MillisW-1:0] last_q, last_d;
  logic [uvs_pkg::MillisW-1:0] stamp_q, stamp_d;
  logic [uvs_pkg::CountW-1:0]  count_q, count_d;

  logic                        hit;
  logic [uvs_pkg::CountW:0]    count_raw;
  logic                        wrap;
  logic [uvs_pkg::MillisW-1:0] stamp_base;
  logic [uvs_pkg::MillisW-1:0] stamp_new;
  logic [uvs_pkg::CountW-1:0]  count_new;

  always_comb begin
    hit        = (last_q == row_i.millis) && (count_q != '0);
    count_raw  = hit ? ({1'b0, count_q} + 1'b1)
                     : ({{(uvs_pkg::CountW + 1 - uvs_pkg::SeedW){1'b0}}, row_i.random_seed}
                        + 1'b1);
    // The counter can only reach its limit by incrementing from all ones.
    wrap       = count_raw[uvs_pkg::CountW];
    stamp_base = hit ? stamp_q : row_i.millis;
    stamp_new  = wrap ? (stamp_base + 1'b1) : stamp_base;
    count_new  = wrap ? {{(uvs_pkg::CountW - 1){1'b0}}, 1'b1}
                      : count_raw[uvs_pkg::CountW-1:0];

    last_d  = last_q;
    stamp_d = stamp_q;
    count_d = count_q;
    if (!row_i.row_is_null) begin
      last_d  = hit ? last_q : row_i.millis;
      stamp_d = stamp_new;
      count_d = count_new;
    end

    if (row_i.row_is_null) begin
      res_o.uuid_high = '0;
      res_o.uuid_low  = '0;
      res_o.is_null   = 1'b1;
    end else begin
      res_o.uuid_high = {stamp_new, uvs_pkg::UuidVersion, count_new[41:30]};
      res_o.uuid_low  = {uvs_pkg::UuidVariant, count_new[29:0], row_i.random_low};
      res_o.is_null   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      stamp_q <= '0;
      count_q <= '0;
    end else if (en_i) begin
      last_q  <= last_d;
      stamp_q <= stamp_d;
      count_q <= count_d;
    end
  end

endmodule
